/* hw/rtl/pgmd_pkg.sv */
// ============================================================================
// pgmd_pkg: shared types, constants and functions of the proximity grid
// motion detector.
// ============================================================================
package pgmd_pkg;

	localparam int unsigned CellCount = 16;
	localparam logic [16:0] OneQ16    = 17'd65536;
	localparam logic [24:0] ZLimit    = 25'd10737419;

	// Configuration register indexes.
	localparam logic [1:0] RegThreshold = 2'd0;
	localparam logic [1:0] RegKeep      = 2'd1;
	localparam logic [1:0] RegWarp      = 2'd2;

	typedef logic signed [2:0] move_t;

	// Frame summary handed from the front part to the back part.
	typedef struct packed {
		logic [15:0] det_now;
		logic [15:0] det_prev;
		logic [16:0] level;
		logic [16:0] prev_level;
		logic [14:0] frame_time;
	} frame_t;

	// Transition table: index is {prev b, prev a, now b, now a}.
	function automatic move_t move_lookup(input logic [3:0] idx);
		move_t m;
		case (idx)
			4'd1, 4'd6, 4'd7, 4'd8, 4'd14: m = 3'sd1;
			4'd2, 4'd4, 4'd9, 4'd11, 4'd13: m = -3'sd1;
			default: m = 3'sd0;
		endcase
		return m;
	endfunction

	function automatic move_t pair_move(input logic [15:0] dn, input logic [15:0] dp,
			input int unsigned c0, input int unsigned c1);
		return move_lookup({dp[c1], dp[c0], dn[c1], dn[c0]});
	endfunction

endpackage

/* hw/rtl/pgmd_if.sv */
// ============================================================================
// pgmd_if: valid/ready channel carrying one payload.
// ============================================================================
interface pgmd_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/proximity_grid_motion_detector.sv */
// ============================================================================
// proximity_grid_motion_detector: 4x4 proximity frame motion detector.
// Filters and thresholds samples in the front part and computes quadrant
// motion and z rate per frame in the back part.
// ============================================================================
// channel   dir  payload
// in        in   raw_sample[9:0], frame_time[14:0]
// cfg       in   index[1:0], data[16:0]
// out       out  quad_row, quad_col, motion_x/y[18:0], motion_z[24:0], level,
//                last_of_frame
// Each sample passes the front part's sequencer states IDLE, SCALE, MUL and
// UPD; a new sample is taken only in IDLE. In the back part each frame runs
// through the bit-serial z divider over a 34-bit dividend, then emits four
// results; a two-entry queue overlaps it with the next frame's samples.
// Reset clears filters and detect bits and sets the levels to OneQ16. A
// stalled output holds the back part; the front part stalls only when the queue is full.
module proximity_grid_motion_detector (
	input  logic clk,
	input  logic arst_n,
	pgmd_if.sink   in,
	pgmd_if.sink   cfg,
	pgmd_if.source out
);
	import pgmd_pkg::*;

	logic [16:0] thr_q, warp_q;
	logic [8:0]  keep_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 17'd32768;
			keep_q <= 9'd179;
			warp_q <= 17'd16384;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				RegThreshold: thr_q  <= cfg.payload.data;
				RegKeep:      keep_q <= cfg.payload.data[8:0];
				RegWarp:      warp_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	logic   f_valid, f_ready, b_valid, b_ready;
	frame_t f_data, b_data;

	pgmd_front u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready),
		.raw_sample(in.payload.raw_sample), .frame_time(in.payload.frame_time),
		.detect_threshold(thr_q), .filter_keep(keep_q),
		.fr_valid(f_valid), .fr_ready(f_ready), .fr_data(f_data)
	);

	pgmd_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
	);

	pgmd_back u_back (
		.clk, .arst_n,
		.fr_valid(b_valid), .fr_ready(b_ready), .fr_data(b_data),
		.warp_limit(warp_q),
		.out_valid(out.valid), .out_ready(out.ready),
		.quad_row(out.payload.quad_row), .quad_col(out.payload.quad_col),
		.motion_x(out.payload.motion_x), .motion_y(out.payload.motion_y),
		.motion_z(out.payload.motion_z), .level(out.payload.level),
		.last_of_frame(out.payload.last_of_frame)
	);
endmodule

/* hw/rtl/pgmd_front.sv */
// ============================================================================
// pgmd_front: per-sample scaling, filtering and detection.
// Scales each sample, updates its cell filter in the MUL and UPD states, and hands
// a frame summary to the queue after the sixteenth sample.
// ============================================================================
module pgmd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [9:0] raw_sample,
	input  logic [14:0] frame_time,
	input  logic [16:0] detect_threshold,
	input  logic [8:0] filter_keep,
	output logic fr_valid,
	input  logic fr_ready,
	output pgmd_pkg::frame_t fr_data
);
	import pgmd_pkg::*;

	typedef enum logic [2:0] {F_IDLE, F_SCALE, F_MUL, F_UPD, F_PUSH} fstate_t;

	fstate_t     state_q;
	logic [9:0]  raw_q;
	logic [14:0] ft_q;
	logic [16:0] scaled_q;
	logic [16:0] flt_q [CellCount];
	logic [3:0]  cell_q;
	logic [15:0] det_now_q, det_prev_q;
	logic [16:0] min_q, prev_level_q;
	logic [25:0] prod_a_q, prod_b_q;
	logic [8:0]  k_c;
	logic [16:0] scaled_c, f_c;
	logic [26:0] quo_c;
	logic [26:0] sum_c;

	assign k_c = (filter_keep > 9'd256) ? 9'd256 : filter_keep;

	// Scale: 65536 - 65536*off/511, off = 2*(raw-512); quotient by reciprocal
	// 65536*off < 2^25; floor(x/511) = (x*8208) >> 22 adjusted by one compare.
	logic [24:0] num_c;
	logic [39:0] rec_c;
	logic [17:0] qe_c;
	logic [26:0] rem_c;
	always_comb begin
		num_c = {raw_q[7:0], 1'b0, 16'd0};
		rec_c = 40'(num_c) * 40'd8208;
		qe_c  = rec_c[39:22];
		rem_c = 27'(num_c) - 27'(qe_c) * 27'd511;
		quo_c = 27'(qe_c);
		if (rem_c >= 27'd511) quo_c = quo_c + 27'd1;
		if (raw_q >= 10'd768) scaled_c = 17'd0;
		else if (raw_q < 10'd512) scaled_c = OneQ16;
		else scaled_c = OneQ16 - quo_c[16:0];
	end

	assign sum_c = 27'(prod_a_q) + 27'(prod_b_q);
	assign f_c   = sum_c[24:8];
	assign in_ready = (state_q == F_IDLE);
	assign fr_valid = (state_q == F_PUSH);
	assign fr_data  = '{det_now: det_now_q, det_prev: det_prev_q, level: min_q,
		prev_level: prev_level_q, frame_time: ft_q};

	// Sample sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			cell_q       <= '0;
			det_now_q    <= '0;
			det_prev_q   <= '0;
			min_q        <= OneQ16;
			prev_level_q <= OneQ16;
			for (int i = 0; i < CellCount; i++) flt_q[i] <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						raw_q   <= raw_sample;
						ft_q    <= frame_time;
						state_q <= F_SCALE;
					end
				end
				F_SCALE: begin
					scaled_q <= scaled_c;
					det_now_q[cell_q] <= (scaled_c < detect_threshold);
					state_q <= F_MUL;
				end
				F_MUL: begin
					prod_a_q <= 26'(flt_q[cell_q]) * 26'(k_c);
					prod_b_q <= 26'(scaled_q) * 26'(9'd256 - k_c);
					state_q  <= F_UPD;
				end
				F_UPD: begin
					flt_q[cell_q] <= f_c;
					if (f_c < min_q) min_q <= f_c;
					if (cell_q == 4'd15) state_q <= F_PUSH;
					else begin
						cell_q  <= cell_q + 4'd1;
						state_q <= F_IDLE;
					end
				end
				F_PUSH: begin
					if (fr_ready) begin
						prev_level_q <= min_q;
						min_q        <= OneQ16;
						det_prev_q   <= det_now_q;
						cell_q       <= '0;
						state_q      <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/pgmd_queue.sv */
// ============================================================================
// pgmd_queue: two-entry frame summary queue between front and back parts.
// ============================================================================
module pgmd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  pgmd_pkg::frame_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output pgmd_pkg::frame_t rd_data
);
	import pgmd_pkg::*;

	frame_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hw/rtl/pgmd_back.sv */
// ============================================================================
// pgmd_back: frame motion and z rate.
// Computes quadrant x/y motion from detect bits, the z rate by a restoring
// divider, and emits four quadrant results through an output register.
// ============================================================================
module pgmd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic fr_valid,
	output logic fr_ready,
	input  pgmd_pkg::frame_t fr_data,
	input  logic [16:0] warp_limit,
	output logic out_valid,
	input  logic out_ready,
	output logic quad_row,
	output logic quad_col,
	output logic signed [18:0] motion_x,
	output logic signed [18:0] motion_y,
	output logic signed [24:0] motion_z,
	output logic [16:0] level,
	output logic last_of_frame
);
	import pgmd_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_PREP, B_DIV, B_EMIT} bstate_t;

	bstate_t            state_q;
	logic signed [18:0] mx_q [4];
	logic signed [18:0] my_q [4];
	logic [16:0]        level_q;
	logic               neg_q, zero_q;
	logic [22:0]        div_q;   // 2*ft*100
	logic [33:0]        num_q;   // shifting dividend
	logic [34:0]        rem_q;
	logic [33:0]        quo_q;
	logic [5:0]         bit_q;
	logic [1:0]         quad_q;

	// Sum in [-6,6] times 65536 over 3, truncated toward zero.
	function automatic logic signed [18:0] div3(input logic signed [5:0] s);
		logic signed [24:0] p;
		logic [24:0]        a;
		logic [24:0]        q;
		p = 25'(s) <<< 16;
		a = p[24] ? 25'(-p) : 25'(p);
		q = 25'((49'(a) * 49'd11184811) >> 25);
		return p[24] ? -19'(q) : 19'(q);
	endfunction

	// Combinational motion of one frame summary.
	logic signed [18:0] mx_c [4];
	logic signed [18:0] my_c [4];
	always_comb begin
		logic signed [3:0] m0, m1, m2;
		logic signed [5:0] s;
		for (int i = 0; i < 2; i++) begin
			m0 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i, 8*i+1))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i+4, 8*i+5));
			m1 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i+1, 8*i+2))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i+5, 8*i+6));
			m2 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i+2, 8*i+3))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8*i+6, 8*i+7));
			s = 6'(m0) * 6'sd2 + 6'(m1);
			mx_c[(1-i)*2]   = div3(s);
			s = 6'(m1) + 6'(m2) * 6'sd2;
			mx_c[(1-i)*2+1] = div3(s);
			m0 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 2*i, 4+2*i))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 2*i+1, 5+2*i));
			m1 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 4+2*i, 8+2*i))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 5+2*i, 9+2*i));
			m2 = 4'(pair_move(fr_data.det_now, fr_data.det_prev, 8+2*i, 12+2*i))
				+ 4'(pair_move(fr_data.det_now, fr_data.det_prev, 9+2*i, 13+2*i));
			s = 6'(m0) * 6'sd2 + 6'(m1);
			my_c[2+i] = div3(s);
			s = 6'(m1) + 6'(m2) * 6'sd2;
			my_c[i]   = div3(s);
		end
	end

	logic signed [17:0] delta_c;
	logic [16:0]        mag_c;
	assign delta_c = $signed({1'b0, fr_data.level}) - $signed({1'b0, fr_data.prev_level});
	assign mag_c   = delta_c[17] ? 17'(-delta_c) : 17'(delta_c);

	logic [34:0] trial_c;
	assign trial_c = {rem_q[33:0], num_q[33]} - 35'(div_q);

	logic [24:0] zq_c;
	assign zq_c = (quo_q > 34'(ZLimit)) ? ZLimit : quo_q[24:0];

	assign fr_ready = (state_q == B_IDLE);

	// Frame sequencer: capture, divide one bit a cycle, emit four results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (fr_valid) begin
						for (int j = 0; j < 4; j++) begin
							mx_q[j] <= mx_c[j];
							my_q[j] <= my_c[j];
						end
						level_q <= fr_data.level;
						neg_q   <= delta_c[17];
						zero_q  <= (mag_c > warp_limit) || (fr_data.frame_time == '0);
						div_q   <= 23'(fr_data.frame_time) * 23'd200;
						// Dividend: mag*2*65536 + ft*100.
						num_q   <= {mag_c, 17'd0} + 34'(fr_data.frame_time) * 34'd100;
						state_q <= B_PREP;
					end
				end
				B_PREP: begin
					rem_q   <= '0;
					quo_q   <= '0;
					bit_q   <= 6'd34;
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (trial_c[34]) rem_q <= {rem_q[33:0], num_q[33]};
					else rem_q <= trial_c;
					quo_q <= {quo_q[32:0], ~trial_c[34]};
					num_q <= {num_q[32:0], 1'b0};
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						quad_q  <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						quad_row      <= quad_q[1];
						quad_col      <= quad_q[0];
						motion_x      <= mx_q[quad_q];
						motion_y      <= my_q[quad_q];
						motion_z      <= zero_q ? '0 : (neg_q ? -zq_c : zq_c);
						level         <= level_q;
						last_of_frame <= (quad_q == 2'd3);
						quad_q        <= quad_q + 2'd1;
						if (quad_q == 2'd3) state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (out_valid && out_ready && state_q != B_EMIT) out_valid <= 1'b0;
		end
	end
endmodule
